@@ design/assert_macros.svh @@
// Assertion macros used by the tile address core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BATA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BATA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) \
        else $error(msg);

`endif

@@ design/bata_pkg.sv @@
// Shared types, constants and the divider step for the tile address core.
package bata_pkg;

    // Field and register widths
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned EDGE_W   = 9;
    localparam int unsigned OFS_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Bounds applied to the configuration
    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int unsigned MAX_TILE_EDGE = 256;

    // Divider pipeline shape: quotient bits per stage times stages covers the coordinate
    localparam int unsigned DIV_STAGES      = 4;
    localparam int unsigned STEPS_PER_STAGE = COORD_W / DIV_STAGES;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARRAY_WIDTH  = 2'd0,
        CFG_ARRAY_HEIGHT = 2'd1,
        CFG_TILE_EDGE    = 2'd2
    } t_cfg_idx;

    // Working state of one restoring divider: partial remainder and shifting numerator
    typedef struct packed {
        logic [EDGE_W-1:0]  rem;
        logic [COORD_W-1:0] num;
    } t_div_state;

    // One restoring division step: bring down the next bit, subtract if it fits
    function automatic t_div_state div_step(input t_div_state s,
                                            input logic [EDGE_W-1:0] e);
        logic [EDGE_W:0] t;
        t_div_state      r;
        t     = {s.rem, s.num[COORD_W-1]};
        r.num = {s.num[COORD_W-2:0], 1'b0};
        if (t >= {1'b0, e}) begin
            r.rem    = EDGE_W'(t - {1'b0, e});
            r.num[0] = 1'b1;
        end else begin
            r.rem = t[EDGE_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/blocked_array_tile_address_core.sv @@
// Top level: tile address generator for a 2-D array stored as square tiles.
//
// Usage:
//   Request channel: drive i_column/i_row with start high. busy is always low,
//   so a request is taken at every rising edge where start is high.
//   Result channel: o_result_valid is high for one cycle with o_tile_column,
//   o_tile_row, o_offset_in_tile and o_range_error. Results cannot be held off.
//   Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index
//   (0 array width, 1 array height, 2 tile edge) at the clock edge; change it
//   only while no request is in flight.
// Timing:
//   One request per cycle, sustained. A request's result is registered through
//   four divider stages (three quotient bits each, column and row in parallel),
//   one multiply stage for edge times row remainder and one output stage that
//   adds the column remainder and applies the range check.
// Reset:
//   Synchronous, active low. Clears in-flight valid bits and sets width and
//   height to 0 and tile edge to 1, so every request then reports range error.
module blocked_array_tile_address_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [bata_pkg::COORD_W-1:0]    i_column,
    input  logic [bata_pkg::COORD_W-1:0]    i_row,
    // Result channel
    output logic                            o_result_valid,
    output logic [bata_pkg::COORD_W-1:0]    o_tile_column,
    output logic [bata_pkg::COORD_W-1:0]    o_tile_row,
    output logic [bata_pkg::OFS_W-1:0]      o_offset_in_tile,
    output logic                            o_range_error,
    // Configuration port
    input  logic                            i_cfg_wr_en,
    input  logic [bata_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bata_pkg::DIM_W-1:0]      i_cfg_wdata
);

`include "assert_macros.svh"

    localparam int unsigned PIPE_DEPTH = bata_pkg::DIV_STAGES + 2;
    localparam int unsigned MUL_IDX    = bata_pkg::DIV_STAGES;
    localparam int unsigned DIV_IDX    = bata_pkg::DIV_STAGES - 1;

    // Configuration registers
    logic [bata_pkg::DIM_W-1:0]  r_array_width;
    logic [bata_pkg::DIM_W-1:0]  r_array_height;
    logic [bata_pkg::EDGE_W-1:0] r_tile_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_width  <= '0;
            r_array_height <= '0;
            r_tile_edge    <= bata_pkg::EDGE_W'(1);
        end else if (i_cfg_wr_en) begin
            case (bata_pkg::t_cfg_idx'(i_cfg_index))
                bata_pkg::CFG_ARRAY_WIDTH:  r_array_width  <= i_cfg_wdata;
                bata_pkg::CFG_ARRAY_HEIGHT: r_array_height <= i_cfg_wdata;
                bata_pkg::CFG_TILE_EDGE:    r_tile_edge    <= i_cfg_wdata[bata_pkg::EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective bounds and edge after clamping
    logic [bata_pkg::DIM_W-1:0]  w_width_eff;
    logic [bata_pkg::DIM_W-1:0]  w_height_eff;
    logic [bata_pkg::EDGE_W-1:0] w_edge_eff;

    always_comb begin
        w_width_eff  = (32'(r_array_width) > bata_pkg::MAX_DIMENSION) ?
                       bata_pkg::DIM_W'(bata_pkg::MAX_DIMENSION) : r_array_width;
        w_height_eff = (32'(r_array_height) > bata_pkg::MAX_DIMENSION) ?
                       bata_pkg::DIM_W'(bata_pkg::MAX_DIMENSION) : r_array_height;
        if (r_tile_edge == '0) begin
            w_edge_eff = bata_pkg::EDGE_W'(1);
        end else if (32'(r_tile_edge) > bata_pkg::MAX_TILE_EDGE) begin
            w_edge_eff = bata_pkg::EDGE_W'(bata_pkg::MAX_TILE_EDGE);
        end else begin
            w_edge_eff = r_tile_edge;
        end
    end

    // Requests are never refused
    assign busy = 1'b0;

    logic w_accept;
    logic w_out_of_bounds;
    assign w_accept        = start && !busy;
    assign w_out_of_bounds = ({1'b0, i_column} >= w_width_eff) ||
                             ({1'b0, i_row} >= w_height_eff);

    // Valid and range-error bits travel with the data
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_err <= {r_err[PIPE_DEPTH-2:0], w_out_of_bounds};
    end

    // Column and row dividers
    logic [bata_pkg::COORD_W-1:0] w_col_quo;
    logic [bata_pkg::COORD_W-1:0] w_row_quo;
    logic [bata_pkg::EDGE_W-1:0]  w_col_rem;
    logic [bata_pkg::EDGE_W-1:0]  w_row_rem;

    bata_div u_col_div (
        .i_clk       (i_clk),
        .i_dividend  (i_column),
        .i_divisor   (w_edge_eff),
        .o_quotient  (w_col_quo),
        .o_remainder (w_col_rem)
    );

    bata_div u_row_div (
        .i_clk       (i_clk),
        .i_dividend  (i_row),
        .i_divisor   (w_edge_eff),
        .o_quotient  (w_row_quo),
        .o_remainder (w_row_rem)
    );

    // Multiply stage: edge times row remainder (max 256 * 255, fits the offset)
    logic [bata_pkg::OFS_W-1:0]   r_prod;
    logic [bata_pkg::EDGE_W-1:0]  r_col_rem;
    logic [bata_pkg::COORD_W-1:0] r_tile_col;
    logic [bata_pkg::COORD_W-1:0] r_tile_row;

    always_ff @(posedge i_clk) begin
        r_prod     <= bata_pkg::OFS_W'(w_edge_eff * w_row_rem);
        r_col_rem  <= w_col_rem;
        r_tile_col <= w_col_quo;
        r_tile_row <= w_row_quo;
    end

    // Output stage: final add, zero fields on a range error
    logic [bata_pkg::COORD_W-1:0] r_out_col;
    logic [bata_pkg::COORD_W-1:0] r_out_row;
    logic [bata_pkg::OFS_W-1:0]   r_out_ofs;

    always_ff @(posedge i_clk) begin
        if (r_err[MUL_IDX]) begin
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_ofs <= '0;
        end else begin
            r_out_col <= r_tile_col;
            r_out_row <= r_tile_row;
            r_out_ofs <= r_prod + bata_pkg::OFS_W'(r_col_rem);
        end
    end

    assign o_result_valid   = r_vld[PIPE_DEPTH-1];
    assign o_range_error    = r_err[PIPE_DEPTH-1];
    assign o_tile_column    = r_out_col;
    assign o_tile_row       = r_out_row;
    assign o_offset_in_tile = r_out_ofs;

    // Every result strobe traces back to a request at the pipeline input
    `BATA_ASSERT_SAME(a_result_has_request, i_clk, i_rst_n, o_result_valid,
        $past(start, PIPE_DEPTH), "result strobe without a matching request")

    // An out-of-bounds request comes out flagged after the pipeline depth
    `BATA_ASSERT_SAME(a_oob_flagged, i_clk, i_rst_n, w_accept && w_out_of_bounds,
        ##PIPE_DEPTH (o_result_valid && o_range_error), "out-of-bounds request not flagged")

    // Divider remainders must be below the tile edge
    `BATA_ASSERT_SAME(a_rem_below_edge, i_clk, i_rst_n, r_vld[DIV_IDX] && !r_err[DIV_IDX],
        (w_col_rem < w_edge_eff && w_row_rem < w_edge_eff), "remainder not below edge")

    // A flagged item leaves the multiply stage and comes out with zero fields
    `BATA_ASSERT_NEXT(a_err_zero_fields, i_clk, i_rst_n, r_vld[MUL_IDX] && r_err[MUL_IDX],
        (o_tile_column == '0 && o_tile_row == '0 && o_offset_in_tile == '0),
        "range error result carries nonzero fields")

endmodule

@@ design/bata_div.sv @@
// Pipelined restoring divider: coordinate by tile edge, a few quotient bits per stage.
module bata_div (
    input  logic                          i_clk,
    input  logic [bata_pkg::COORD_W-1:0]  i_dividend,
    input  logic [bata_pkg::EDGE_W-1:0]   i_divisor,
    output logic [bata_pkg::COORD_W-1:0]  o_quotient,
    output logic [bata_pkg::EDGE_W-1:0]   o_remainder
);

    bata_pkg::t_div_state r_st [bata_pkg::DIV_STAGES];
    bata_pkg::t_div_state n_st [bata_pkg::DIV_STAGES];

    // Each stage resolves STEPS_PER_STAGE quotient bits, MSB first
    always_comb begin
        n_st[0].rem = '0;
        n_st[0].num = i_dividend;
        for (int s = 1; s < bata_pkg::DIV_STAGES; s++) begin
            n_st[s] = r_st[s-1];
        end
        for (int s = 0; s < bata_pkg::DIV_STAGES; s++) begin
            for (int k = 0; k < bata_pkg::STEPS_PER_STAGE; k++) begin
                n_st[s] = bata_pkg::div_step(n_st[s], i_divisor);
            end
        end
    end

    // Stage registers, advance every cycle
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < bata_pkg::DIV_STAGES; s++) begin
            r_st[s] <= n_st[s];
        end
    end

    assign o_quotient  = r_st[bata_pkg::DIV_STAGES-1].num;
    assign o_remainder = r_st[bata_pkg::DIV_STAGES-1].rem;

endmodule

@@ verif/tb_tile_addr_checker.sv @@
// Checker for the tile address core: tracks the register writes, predicts each result, compares.
module tb_tile_addr_checker
    import bata_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [COORD_W-1:0]   i_column,
    input  logic [COORD_W-1:0]   i_row,
    input  logic                 o_result_valid,
    input  logic [COORD_W-1:0]   o_tile_column,
    input  logic [COORD_W-1:0]   o_tile_row,
    input  logic [OFS_W-1:0]     o_offset_in_tile,
    input  logic                 o_range_error,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    output int                   fail_count,
    output int                   addrs_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] tile_column;
        logic [COORD_W-1:0] tile_row;
        logic [OFS_W-1:0]   offset;
        logic               range_error;
    } t_tile_addr;

    // Shadow copy of the geometry registers
    logic [DIM_W-1:0]  arr_width;
    logic [DIM_W-1:0]  arr_height;
    logic [EDGE_W-1:0] tile_len;

    // Addresses predicted for accepted requests, oldest first
    t_tile_addr expected_addrs[$];

    initial begin
        fail_count    = 0;
        addrs_waiting = 0;
    end

    // Tile coordinates and in-tile offset for one element under the current geometry
    function automatic t_tile_addr compute_tile_addr(input logic [COORD_W-1:0] col,
                                                     input logic [COORD_W-1:0] row);
        int unsigned w;
        int unsigned h;
        int unsigned e;
        t_tile_addr  a;
        w = (arr_width  > MAX_DIMENSION) ? MAX_DIMENSION : arr_width;
        h = (arr_height > MAX_DIMENSION) ? MAX_DIMENSION : arr_height;
        e = (tile_len   > MAX_TILE_EDGE) ? MAX_TILE_EDGE : tile_len;
        if (e == 0) e = 1;
        a = '0;
        if (col >= w || row >= h) begin
            a.range_error = 1'b1;
        end else begin
            a.tile_column = COORD_W'(col / e);
            a.tile_row    = COORD_W'(row / e);
            a.offset      = OFS_W'(e * (row % e) + (col % e));
        end
        return a;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Everything is sampled at the rising edge, before the block's outputs move
    always @(posedge i_clk) begin
        t_tile_addr want;
        if (!i_rst_n) begin
            arr_width  <= '0;
            arr_height <= '0;
            tile_len   <= EDGE_W'(1);
            expected_addrs.delete();
        end else begin
            // result side
            if (o_result_valid) begin
                if (expected_addrs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual col %0d row %0d ofs %0d err %0b",
                             $time, o_tile_column, o_tile_row, o_offset_in_tile, o_range_error);
                    fail_count++;
                end else begin
                    want = expected_addrs.pop_front();
                    check_field("tile_column", want.tile_column, o_tile_column);
                    check_field("tile_row", want.tile_row, o_tile_row);
                    check_field("offset_in_tile", want.offset, o_offset_in_tile);
                    check_field("range_error", want.range_error, o_range_error);
                end
            end
            // request side uses the geometry in force before this edge
            if (start && !busy)
                expected_addrs.push_back(compute_tile_addr(i_column, i_row));
            // register writes; a spare index is ignored
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ARRAY_WIDTH:  arr_width  <= i_cfg_wdata;
                    CFG_ARRAY_HEIGHT: arr_height <= i_cfg_wdata;
                    CFG_TILE_EDGE:    tile_len   <= i_cfg_wdata[EDGE_W-1:0];
                    default: ;
                endcase
            end
        end
        addrs_waiting = expected_addrs.size();
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the tile address core: reset, geometry setup, directed and random requests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bata_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned N_PHASES         = 12;
    localparam int unsigned ITEMS_PER_PHASE  = 160;
    localparam int unsigned TAIL_CYCLES      = 12;
    // index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [COORD_W-1:0]   i_column;
    logic [COORD_W-1:0]   i_row;
    logic                 o_result_valid;
    logic [COORD_W-1:0]   o_tile_column;
    logic [COORD_W-1:0]   o_tile_row;
    logic [OFS_W-1:0]     o_offset_in_tile;
    logic                 o_range_error;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_wdata;

    int          fail_count;
    int          addrs_waiting;
    int unsigned cycle_count;
    int unsigned idle_pct;
    // effective array bounds, used only to steer coordinates
    int unsigned bound_w;
    int unsigned bound_h;

    blocked_array_tile_address_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_column         (i_column),
        .i_row            (i_row),
        .o_result_valid   (o_result_valid),
        .o_tile_column    (o_tile_column),
        .o_tile_row       (o_tile_row),
        .o_offset_in_tile (o_offset_in_tile),
        .o_range_error    (o_range_error),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    tb_tile_addr_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_column         (i_column),
        .i_row            (i_row),
        .o_result_valid   (o_result_valid),
        .o_tile_column    (o_tile_column),
        .o_tile_row       (o_tile_row),
        .o_offset_in_tile (o_offset_in_tile),
        .o_range_error    (o_range_error),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .fail_count       (fail_count),
        .addrs_waiting    (addrs_waiting)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Run guard
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // One request; entered and left at a falling edge, with random idle cycles ahead of it
    task automatic send_addr(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start    = 1'b1;
        i_column = col;
        i_row    = row;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Stop requesting and wait until every predicted address has come back
    task automatic drain();
        start = 1'b0;
        while (addrs_waiting != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // New geometry, only once the pipeline is empty
    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [DIM_W-1:0] e);
        drain();
        write_reg(CFG_ARRAY_WIDTH, w);
        write_reg(CFG_ARRAY_HEIGHT, h);
        write_reg(CFG_TILE_EDGE, e);
        bound_w = (w > MAX_DIMENSION) ? MAX_DIMENSION : w;
        bound_h = (h > MAX_DIMENSION) ? MAX_DIMENSION : h;
    endtask

    // Mostly inside the bounds, some right at the bound, the rest anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned bound);
        int unsigned roll;
        roll = $urandom_range(99);
        if (bound == 0 || roll < 12)
            return COORD_W'($urandom_range(0, 4095));
        if (roll < 17)
            return COORD_W'((bound > 4095) ? 4095 : bound);
        return COORD_W'($urandom_range(0, bound - 1));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(99) < 60)
            return DIM_W'($urandom_range(1, 4096));
        return DIM_W'($urandom_range(0, 8191));
    endfunction

    initial begin
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] e;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_column    = '0;
        i_row       = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_ARRAY_WIDTH;
        i_cfg_wdata = '0;
        idle_pct    = 0;
        bound_w     = 0;
        bound_h     = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry is an empty array: everything is out of range
        send_addr(12'd0, 12'd0);
        send_addr(12'd4095, 12'd4095);
        // A write to the spare index changes nothing
        drain();
        write_reg(CFG_SPARE_IDX, 13'h1FFF);
        send_addr(12'd0, 12'd0);
        // Zero tile edge behaves as one
        set_geometry(13'd4096, 13'd4096, 13'd0);
        send_addr(12'd0, 12'd0);
        send_addr(12'd4095, 12'd4095);
        send_addr(12'd4095, 12'd0);
        send_addr(12'd0, 12'd4095);
        send_addr(12'd2730, 12'd1365);
        // Largest tile edge, largest offset
        set_geometry(13'd4096, 13'd4096, 13'd256);
        send_addr(12'd4095, 12'd4095);
        send_addr(12'd0, 12'd0);
        send_addr(12'd255, 12'd256);
        send_addr(12'd256, 12'd255);
        // Oversized dimensions and tile edge are clamped
        set_geometry(13'd8191, 13'd5000, 13'd511);
        send_addr(12'd4095, 12'd4095);
        send_addr(12'd0, 12'd4095);
        send_addr(12'd100, 12'd3000);
        // One-element array
        set_geometry(13'd1, 13'd1, 13'd3);
        send_addr(12'd0, 12'd0);
        send_addr(12'd1, 12'd0);
        send_addr(12'd0, 12'd1);
        // Empty in one dimension only
        set_geometry(13'd4095, 13'd0, 13'd7);
        send_addr(12'd0, 12'd0);
        // Coordinates just inside and exactly at the bound
        set_geometry(13'd4095, 13'd4095, 13'd7);
        send_addr(12'd4094, 12'd4094);
        send_addr(12'd4095, 12'd0);
        send_addr(12'd0, 12'd4095);

        // Random phases, each with its own geometry and sender idling
        for (int unsigned p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin w = 13'd4096; h = 13'd4096; e = 13'd256;  end
                1: begin w = 13'h1FFF; h = 13'h1FFF; e = 13'h1FFF; end
                2: begin w = 13'd1;    h = 13'd1;    e = 13'd1;    end
                3: begin w = 13'd0;    h = 13'd4096; e = 13'd9;    end
                default: begin
                    w = pick_dim();
                    h = pick_dim();
                    e = ($urandom_range(99) < 75) ? DIM_W'($urandom_range(1, 256))
                                                   : DIM_W'($urandom_range(0, 8191));
                end
            endcase
            set_geometry(w, h, e);
            case (p % 4)
                0: idle_pct = 0;
                1: idle_pct = 70;
                2: idle_pct = 0;
                default: idle_pct = 24;
            endcase
            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++)
                send_addr(pick_coord(bound_w), pick_coord(bound_h));
        end

        // Let the pipeline empty, then watch for stray results
        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ blocked_array_tile_address_core.f @@
+incdir+design
design/bata_pkg.sv
design/bata_div.sv
design/blocked_array_tile_address_core.sv
verif/tb_tile_addr_checker.sv
verif/tb_top.sv
